// ===== hw/rtl/plc_pkg.sv =====
// Package for the piecewise-linear curve block: field widths, reset values,
// configuration register indexes and the signed divide-by-ten helper.
// No dependencies.
package plc_pkg;

    localparam int SAMPLE_W   = 16;  // input and output sample width
    localparam int SEG_W      = 4;   // segment index width
    localparam int NODE_W     = 8;   // one curve node
    localparam int CFG_W      = 64;  // configuration data width
    localparam int CFG_IDX_W  = 3;   // configuration register index width
    localparam int CNT_W      = 5;   // node_count register
    localparam int MAXV_W     = 15;  // max_value register
    localparam int GAIN_W     = 12;  // gain register
    localparam int VAL_W      = 15;  // clamped sample
    localparam int THR_W      = 19;  // value times (count-1), segment thresholds
    localparam int NPROD_W    = 21;  // node times gain
    localparam int SC_W       = 17;  // scaled node
    localparam int DIFF_W     = 18;  // difference of two scaled nodes
    localparam int DMAG_W     = 17;  // magnitude of that difference
    localparam int PROD_W     = 32;  // offset times difference magnitude
    localparam int SUM_W      = 34;  // final sum before saturation

    localparam logic [CNT_W-1:0]  RST_COUNT = 5'd2;
    localparam logic [MAXV_W-1:0] RST_MAX   = 15'd1000;
    localparam logic [GAIN_W-1:0] RST_GAIN  = 12'd10;

    // floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for x below 2^22
    localparam logic [19:0] DIV10_MUL   = 20'd838861;
    localparam int          DIV10_SHIFT = 23;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_LO = 3'd0,
        CFG_NODE_HI = 3'd1,
        CFG_COUNT   = 3'd2,
        CFG_MAX     = 3'd3,
        CFG_GAIN    = 3'd4
    } t_cfg_idx;

    // Signed divide by ten, truncating toward zero.
    function automatic logic signed [SC_W-1:0] div10(input logic signed [NPROD_W-1:0] p);
        logic [NPROD_W-1:0] mag;
        logic [39:0]        q40;
        logic [SC_W-1:0]    q;
        mag = p[NPROD_W-1] ? NPROD_W'(-p) : NPROD_W'(p);
        q40 = 40'(mag[19:0]) * 40'(DIV10_MUL);
        q   = {1'b0, q40[DIV10_SHIFT+15:DIV10_SHIFT]};
        return p[NPROD_W-1] ? $signed(-q) : $signed(q);
    endfunction

endpackage

// ===== hw/rtl/piecewise_linear_curve.sv =====
// Piecewise-linear curve over evenly spaced signed nodes, fully pipelined.
// Depends on plc_pkg.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry i_sample_value. Output channel:
//   o_out_valid / i_out_stall carry o_curve_value and o_segment_index. A
//   transaction completes on a rising edge with valid high and stall low.
//   Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index, i_cfg_data.
//   Indexes: 0 node word low, 1 node word high, 2 node count, 3 max value, 4 gain.
// Pipeline: input register, five datapath stages, a 32-stage restoring divider and an
//   output register. Throughput: one sample per cycle while o_in_stall is low;
//   every stage advances each cycle unless the skid entry is full.
// Configuration: each write starts a derivation pass that computes the segment
//   width, the segment thresholds and the scaled node table. o_cfg_ready is low
//   and o_in_stall is high during it. Write only when no sample is in flight.
// Reset: registers take their reset values and the same derivation pass runs.
// Stall: an output register plus one skid entry; the pipeline keeps running
//   until the skid entry fills, then o_in_stall rises and all stages hold.
module piecewise_linear_curve #(
    parameter int MAX_NODES = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [plc_pkg::SAMPLE_W-1:0]    i_sample_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [plc_pkg::SAMPLE_W-1:0]    o_curve_value,
    output logic        [plc_pkg::SEG_W-1:0]       o_segment_index,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic        [plc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        [plc_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int IDX_W     = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int SEQ_LAST  = (MAX_NODES > plc_pkg::MAXV_W - 1) ? MAX_NODES
                                                                 : plc_pkg::MAXV_W - 1;
    localparam int STEP_W    = $clog2(SEQ_LAST + 1);
    localparam int DIV_STEPS = plc_pkg::PROD_W;

    // ---------------- configuration registers ----------------
    logic [plc_pkg::CFG_W-1:0]  r_node_lo, r_node_hi;
    logic [plc_pkg::CNT_W-1:0]  r_count;
    logic [plc_pkg::MAXV_W-1:0] r_max;
    logic [plc_pkg::GAIN_W-1:0] r_gain;

    // ---------------- derived values ----------------
    logic                               r_busy;
    logic [STEP_W-1:0]                  r_step;
    logic [3:0]                         r_wrem;
    logic [plc_pkg::MAXV_W-1:0]         r_width;
    logic [plc_pkg::THR_W-1:0]          r_thr [1:MAX_NODES-1];
    logic                               r_nprod_v;
    logic [IDX_W-1:0]                   r_nprod_idx;
    logic signed [plc_pkg::NPROD_W-1:0] r_nprod;
    logic signed [plc_pkg::SC_W-1:0]    r_prev;
    logic signed [plc_pkg::SC_W-1:0]    r_scaled [0:MAX_NODES-1];
    logic signed [plc_pkg::DIFF_W-1:0]  r_diff [0:MAX_NODES-2];

    logic [plc_pkg::CNT_W-1:0]          w_cnt_eff, w_cm1_full;
    logic [3:0]                         w_cm1;
    logic                               w_pass;
    logic [2*plc_pkg::CFG_W-1:0]        w_nodes;
    logic [IDX_W-1:0]                   w_nidx;
    logic signed [plc_pkg::NPROD_W-1:0] w_node_ext, w_gain_ext;
    logic [4:0]                         w_wtrial;
    logic                               w_wge;
    logic signed [plc_pkg::SC_W-1:0]    w_sc;

    always_comb begin
        w_cnt_eff  = (r_count > plc_pkg::CNT_W'(MAX_NODES)) ? plc_pkg::CNT_W'(MAX_NODES)
                                                           : r_count;
        w_cm1_full = w_cnt_eff - 5'd1;
        w_cm1      = w_cm1_full[3:0];
        w_pass     = (w_cnt_eff < 5'd2) || (r_max == '0);
        w_nodes    = {r_node_hi, r_node_lo};
        w_nidx     = r_step[IDX_W-1:0];
        w_node_ext = plc_pkg::NPROD_W'($signed(w_nodes[{w_nidx, 3'b000} +: plc_pkg::NODE_W]));
        w_gain_ext = $signed({{(plc_pkg::NPROD_W-plc_pkg::GAIN_W){1'b0}}, r_gain});
        // width = max_value / (count-1), one quotient bit per step, MSB first
        w_wtrial   = {r_wrem, r_max[4'(plc_pkg::MAXV_W-1) - r_step[3:0]]};
        w_wge      = w_wtrial >= {1'b0, w_cm1};
        w_sc       = plc_pkg::div10(r_nprod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_lo <= '0;
            r_node_hi <= '0;
            r_count   <= plc_pkg::RST_COUNT;
            r_max     <= plc_pkg::RST_MAX;
            r_gain    <= plc_pkg::RST_GAIN;
            r_busy    <= 1'b1;
            r_step    <= '0;
            r_wrem    <= '0;
            r_nprod_v <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (plc_pkg::t_cfg_idx'(i_cfg_index))
                plc_pkg::CFG_NODE_LO: r_node_lo <= i_cfg_data;
                plc_pkg::CFG_NODE_HI: r_node_hi <= i_cfg_data;
                plc_pkg::CFG_COUNT:   r_count   <= i_cfg_data[plc_pkg::CNT_W-1:0];
                plc_pkg::CFG_MAX:     r_max     <= i_cfg_data[plc_pkg::MAXV_W-1:0];
                plc_pkg::CFG_GAIN:    r_gain    <= i_cfg_data[plc_pkg::GAIN_W-1:0];
                default: ;
            endcase
            r_busy    <= 1'b1;
            r_step    <= '0;
            r_wrem    <= '0;
            r_nprod_v <= 1'b0;
        end else if (r_busy) begin
            if (r_step < STEP_W'(plc_pkg::MAXV_W))
                r_wrem <= w_wge ? 4'(w_wtrial - {1'b0, w_cm1}) : w_wtrial[3:0];
            r_nprod_v <= (r_step < STEP_W'(MAX_NODES));
            if (r_step == STEP_W'(SEQ_LAST))
                r_busy <= 1'b0;
            else
                r_step <= r_step + 1'b1;
        end
    end

    // Derived tables: no reset, rebuilt by every derivation pass.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_step < STEP_W'(plc_pkg::MAXV_W))
                r_width <= {r_width[plc_pkg::MAXV_W-2:0], w_wge};
            if (r_step >= STEP_W'(1) && r_step < STEP_W'(MAX_NODES))
                r_thr[w_nidx] <= plc_pkg::THR_W'(r_step) * plc_pkg::THR_W'(r_max);
            r_nprod     <= w_node_ext * w_gain_ext;
            r_nprod_idx <= w_nidx;
            if (r_nprod_v) begin
                r_scaled[r_nprod_idx] <= w_sc;
                r_prev                <= w_sc;
                if (r_nprod_idx != '0)
                    r_diff[r_nprod_idx - 1'b1] <= {w_sc[plc_pkg::SC_W-1], w_sc}
                                                - {r_prev[plc_pkg::SC_W-1], r_prev};
            end
        end
    end

    assign o_cfg_ready = !r_busy;

    // ---------------- sample pipeline ----------------
    logic r_skid_v, r_out_v;
    logic w_adv, w_take;

    assign w_adv      = !r_skid_v;
    assign o_in_stall = r_busy || r_skid_v;
    assign w_take     = r_out_v && !i_out_stall;

    logic                                r0_v, r1_v, r2_v, r3_v, r4_v;
    logic signed [plc_pkg::SAMPLE_W-1:0] r0_sample, r1_sample, r2_sample, r3_sample;
    logic [plc_pkg::VAL_W-1:0]           r0_val, r1_val, r2_val, r3_val;
    logic [plc_pkg::THR_W-1:0]           r1_prod;
    logic [plc_pkg::SEG_W-1:0]           r2_seg, r3_seg, r4_seg;
    logic signed [plc_pkg::SC_W-1:0]     r3_n1, r4_base;
    logic signed [plc_pkg::DIFF_W-1:0]   r3_diff;
    logic [plc_pkg::THR_W-1:0]           r3_segw;
    logic [plc_pkg::VAL_W-1:0]           r4_offs;
    logic                                r4_neg;
    logic [plc_pkg::DMAG_W-1:0]          r4_dmag;

    // divider stage 0 is fed by the multiply stage
    logic                                r_dv    [0:DIV_STEPS];
    logic [plc_pkg::MAXV_W-1:0]          r_drem  [0:DIV_STEPS];
    logic [plc_pkg::PROD_W-1:0]          r_dq    [0:DIV_STEPS];
    logic signed [plc_pkg::SC_W-1:0]     r_dbase [0:DIV_STEPS];
    logic [plc_pkg::SEG_W-1:0]           r_dseg  [0:DIV_STEPS];
    logic                                r_dneg  [0:DIV_STEPS];

    logic [plc_pkg::VAL_W-1:0]           w_clamp;
    logic [plc_pkg::SEG_W-1:0]           w_seg;
    logic [IDX_W-1:0]                    w_sidx;
    logic [plc_pkg::THR_W-1:0]           w_offs_full;
    logic [plc_pkg::DIFF_W-1:0]          w_dabs;
    logic [plc_pkg::MAXV_W:0]            w_trial [1:DIV_STEPS];
    logic                                w_ge    [1:DIV_STEPS];
    logic signed [plc_pkg::SUM_W-1:0]    w_ln, w_sum;
    logic signed [plc_pkg::SAMPLE_W-1:0] w_curve;

    always_comb begin
        if (i_sample_value[plc_pkg::SAMPLE_W-1])
            w_clamp = '0;
        else if (i_sample_value[plc_pkg::VAL_W-1:0] >= r_max)
            w_clamp = r_max - 1'b1;
        else
            w_clamp = i_sample_value[plc_pkg::VAL_W-1:0];

        // segment = number of thresholds k*max_value at or below value*(count-1)
        w_seg = '0;
        for (int s = 1; s < MAX_NODES; s++)
            w_seg = w_seg + plc_pkg::SEG_W'(r_thr[s] <= r1_prod);

        w_sidx      = r2_seg[IDX_W-1:0];
        w_offs_full = plc_pkg::THR_W'(r3_val) - r3_segw;
        w_dabs      = r3_diff[plc_pkg::DIFF_W-1] ? plc_pkg::DIFF_W'(-r3_diff)
                                                 : plc_pkg::DIFF_W'(r3_diff);

        for (int i = 1; i <= DIV_STEPS; i++) begin
            w_trial[i] = {r_drem[i-1], r_dq[i-1][plc_pkg::PROD_W-1]};
            w_ge[i]    = w_trial[i] >= {1'b0, r_width};
        end

        if (w_pass || r_width == '0)
            w_ln = '0;
        else if (r_dneg[DIV_STEPS])
            w_ln = -$signed({2'b00, r_dq[DIV_STEPS]});
        else
            w_ln = $signed({2'b00, r_dq[DIV_STEPS]});
        w_sum = plc_pkg::SUM_W'(r_dbase[DIV_STEPS]) + w_ln;
        if (w_sum > 34'sd32767)
            w_curve = 16'sh7fff;
        else if (w_sum < -34'sd32768)
            w_curve = 16'sh8000;
        else
            w_curve = w_sum[plc_pkg::SAMPLE_W-1:0];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            for (int i = 0; i <= DIV_STEPS; i++)
                r_dv[i] <= 1'b0;
        end else if (w_adv) begin
            r0_v    <= i_in_valid && !r_busy;
            r1_v    <= r0_v;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r_dv[0] <= r4_v;
            for (int i = 1; i <= DIV_STEPS; i++)
                r_dv[i] <= r_dv[i-1];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_sample <= i_sample_value;
            r0_val    <= w_clamp;

            r1_sample <= r0_sample;
            r1_val    <= r0_val;
            r1_prod   <= plc_pkg::THR_W'(r0_val) * plc_pkg::THR_W'(w_cm1);

            r2_sample <= r1_sample;
            r2_val    <= r1_val;
            r2_seg    <= w_seg;

            r3_sample <= r2_sample;
            r3_val    <= r2_val;
            r3_seg    <= r2_seg;
            r3_n1     <= r_scaled[w_sidx];
            r3_diff   <= r_diff[w_sidx];
            r3_segw   <= plc_pkg::THR_W'(r2_seg) * plc_pkg::THR_W'(r_width);

            r4_base   <= w_pass ? plc_pkg::SC_W'(r3_sample) : r3_n1;
            r4_seg    <= w_pass ? '0 : r3_seg;
            r4_offs   <= w_offs_full[plc_pkg::VAL_W-1:0];
            r4_neg    <= r3_diff[plc_pkg::DIFF_W-1];
            r4_dmag   <= w_dabs[plc_pkg::DMAG_W-1:0];

            r_dq[0]    <= plc_pkg::PROD_W'(r4_offs) * plc_pkg::PROD_W'(r4_dmag);
            r_drem[0]  <= '0;
            r_dbase[0] <= r4_base;
            r_dseg[0]  <= r4_seg;
            r_dneg[0]  <= r4_neg;

            // restoring divide by the segment width, one quotient bit per stage
            for (int i = 1; i <= DIV_STEPS; i++) begin
                r_drem[i]  <= w_ge[i] ? plc_pkg::MAXV_W'(w_trial[i] - {1'b0, r_width})
                                      : w_trial[i][plc_pkg::MAXV_W-1:0];
                r_dq[i]    <= {r_dq[i-1][plc_pkg::PROD_W-2:0], w_ge[i]};
                r_dbase[i] <= r_dbase[i-1];
                r_dseg[i]  <= r_dseg[i-1];
                r_dneg[i]  <= r_dneg[i-1];
            end
        end
    end

    // ---------------- output register and skid entry ----------------
    logic signed [plc_pkg::SAMPLE_W-1:0] r_out_curve, r_skid_curve;
    logic [plc_pkg::SEG_W-1:0]           r_out_seg, r_skid_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (r_dv[DIV_STEPS]) begin
            if (!r_out_v || w_take)
                r_out_v <= 1'b1;
            else
                r_skid_v <= 1'b1;
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out_curve <= r_skid_curve;
                r_out_seg   <= r_skid_seg;
            end
        end else if (r_dv[DIV_STEPS]) begin
            if (!r_out_v || w_take) begin
                r_out_curve <= w_curve;
                r_out_seg   <= r_dseg[DIV_STEPS];
            end else begin
                r_skid_curve <= w_curve;
                r_skid_seg   <= r_dseg[DIV_STEPS];
            end
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_curve_value   = r_out_curve;
    assign o_segment_index = r_out_seg;

endmodule

// ===== hw/rtl/plc_checker.sv =====
// Port-level checker for piecewise_linear_curve, attached by bind.
// Depends on plc_pkg.
module plc_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [plc_pkg::SAMPLE_W-1:0]  o_curve_value,
    input logic        [plc_pkg::SEG_W-1:0]     o_segment_index,
    input logic                                 i_cfg_valid,
    input logic                                 o_cfg_ready
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_curve_value)
                                       && $stable(o_segment_index))
        else $error("result changed while stalled");

    // the lower node of a segment is never the last node
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_segment_index != 4'd15)
        else $error("segment index out of range");

    // samples are held off while derived tables are rebuilt
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cfg_ready |-> o_in_stall)
        else $error("input open during table rebuild");

    // every configuration write starts a rebuild
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !o_cfg_ready && o_in_stall)
        else $error("no rebuild after configuration write");

endmodule

bind piecewise_linear_curve plc_checker u_plc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_curve_value   (o_curve_value),
    .o_segment_index (o_segment_index),
    .i_cfg_valid     (i_cfg_valid),
    .o_cfg_ready     (o_cfg_ready)
);

// ===== dv/curve_checker.sv =====
`timescale 1ns / 100ps
// Checker for piecewise_linear_curve: shadows the configuration registers, predicts
// curve_value and segment_index for every input transaction and compares each output.
// Depends on plc_pkg.
module curve_checker #(
    parameter int MAX_NODES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic signed [plc_pkg::SAMPLE_W-1:0]  i_sample_value,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [plc_pkg::SAMPLE_W-1:0]  i_curve_value,
    input  logic        [plc_pkg::SEG_W-1:0]     i_segment_index,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic        [plc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [plc_pkg::CFG_W-1:0]     i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    localparam longint GAIN_DIV = 10;
    localparam longint SAT_HI   = 32767;
    localparam longint SAT_LO   = -32768;

    typedef struct packed {
        logic [plc_pkg::SAMPLE_W-1:0] value;
        logic [plc_pkg::SEG_W-1:0]    seg;
    } t_curve_result;

    logic [plc_pkg::CFG_W-1:0]  r_node_lo;
    logic [plc_pkg::CFG_W-1:0]  r_node_hi;
    logic [plc_pkg::CNT_W-1:0]  r_node_count;
    logic [plc_pkg::MAXV_W-1:0] r_max_value;
    logic [plc_pkg::GAIN_W-1:0] r_gain;

    t_curve_result expected_curve[$];
    t_curve_result want;
    int            fails = 0;

    assign o_fail_count = fails;

    function automatic longint node_at(input int idx);
        logic signed [plc_pkg::NODE_W-1:0] b;
        b = (idx >= 8) ? r_node_hi[(idx-8)*plc_pkg::NODE_W +: plc_pkg::NODE_W]
                       : r_node_lo[idx*plc_pkg::NODE_W +: plc_pkg::NODE_W];
        return longint'(b);
    endfunction

    function automatic t_curve_result map_sample(
        input logic signed [plc_pkg::SAMPLE_W-1:0] sample
    );
        longint                    val, cnt, mx, width, n1, n2, ln, sum;
        logic [plc_pkg::SEG_W-1:0] seg;
        t_curve_result             r;
        val = longint'(sample);
        cnt = longint'(r_node_count);
        mx  = longint'(r_max_value);
        seg = '0;
        if (cnt > MAX_NODES) cnt = MAX_NODES;
        if (cnt < 2 || mx == 0) begin
            sum = val;
        end else begin
            if (val < 0) val = 0;
            if (val >= mx) val = mx - 1;
            width = mx / (cnt - 1);
            seg   = plc_pkg::SEG_W'((val * (cnt - 1)) / mx);
            n1    = (node_at(int'(seg)) * longint'(r_gain)) / GAIN_DIV;
            n2    = (node_at((int'(seg) + 1) % 16) * longint'(r_gain)) / GAIN_DIV;
            // truncated width can leave the last segment long: keeps extrapolating
            ln    = (width == 0) ? 0
                                 : ((val - longint'(seg) * width) * (n2 - n1)) / width;
            sum   = n1 + ln;
            if (sum > SAT_HI) sum = SAT_HI;
            if (sum < SAT_LO) sum = SAT_LO;
        end
        r.value = plc_pkg::SAMPLE_W'(sum);
        r.seg   = seg;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_lo    <= '0;
            r_node_hi    <= '0;
            r_node_count <= plc_pkg::RST_COUNT;
            r_max_value  <= plc_pkg::RST_MAX;
            r_gain       <= plc_pkg::RST_GAIN;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    plc_pkg::CFG_NODE_LO: r_node_lo    <= i_cfg_data;
                    plc_pkg::CFG_NODE_HI: r_node_hi    <= i_cfg_data;
                    plc_pkg::CFG_COUNT:   r_node_count <= i_cfg_data[plc_pkg::CNT_W-1:0];
                    plc_pkg::CFG_MAX:     r_max_value  <= i_cfg_data[plc_pkg::MAXV_W-1:0];
                    plc_pkg::CFG_GAIN:    r_gain       <= i_cfg_data[plc_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_curve.push_back(map_sample(i_sample_value));
            if (i_out_valid && !i_out_stall) begin
                if (expected_curve.size() == 0) begin
                    $display("%0t: unexpected output transaction curve_value %0d segment %0d",
                             $time, i_curve_value, i_segment_index);
                    fails++;
                end else begin
                    want = expected_curve.pop_front();
                    if (want.value !== i_curve_value) begin
                        $display("%0t: curve_value mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.value), i_curve_value);
                        fails++;
                    end
                    if (want.seg !== i_segment_index) begin
                        $display("%0t: segment_index mismatch: expected %0d, actual %0d",
                                 $time, want.seg, i_segment_index);
                        fails++;
                    end
                end
            end
        end
        o_pending <= expected_curve.size();
    end

endmodule

// ===== dv/tb_piecewise_linear_curve.sv =====
`timescale 1ns / 100ps
// Top of the piecewise_linear_curve testbench: clock, reset, stimulus and verdict.
// Depends on plc_pkg, piecewise_linear_curve and curve_checker.
module tb_piecewise_linear_curve;

    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int TAIL_CYCLES = 45;
    localparam int NUM_SWING   = 11;
    localparam logic [plc_pkg::CFG_IDX_W-1:0] CFG_SPARE   = 3'd7;  // not mapped to a register
    localparam logic [plc_pkg::CFG_W-1:0]     NODES_SWING = 64'h807F_807F_807F_807F;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid;
    logic                                in_stall;
    logic signed [plc_pkg::SAMPLE_W-1:0] sample_value;
    logic                                out_valid;
    logic                                out_stall;
    logic signed [plc_pkg::SAMPLE_W-1:0] curve_value;
    logic [plc_pkg::SEG_W-1:0]           segment_index;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [plc_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [plc_pkg::CFG_W-1:0]           cfg_data;
    int                                  fail_count;
    int                                  pending;
    bit                                  calm;        // phase without idle cycles
    int                                  cur_max;

    piecewise_linear_curve dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_sample_value  (sample_value),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_curve_value   (curve_value),
        .o_segment_index (segment_index),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    curve_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_sample_value  (sample_value),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_curve_value   (curve_value),
        .i_segment_index (segment_index),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("tb_piecewise_linear_curve NOT OK");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly inside the curve span, some anywhere, some on the edges
    function automatic int pick_sample(input int mx);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6 && mx > 0) return int'($urandom_range(0, mx - 1));
        if (r < 8) return int'($urandom);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return -1;
            2: return mx - 1;
            3: return mx;
            4: return -32768;
            default: return 32767;
        endcase
    endfunction

    // receiver side stalls
    initial begin
        out_stall = 1'b0;
        forever begin
            int gap;
            gap = pick_gap();
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat (calm ? 30 : $urandom_range(1, 12)) @(posedge clk);
        end
    end

    task automatic send_sample(input int v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample_value <= plc_pkg::SAMPLE_W'(v);
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [plc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [plc_pkg::CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [plc_pkg::CFG_W-1:0] lo,
                                 input logic [plc_pkg::CFG_W-1:0] hi,
                                 input int cnt, input int mx, input int g);
        write_reg(plc_pkg::CFG_NODE_LO, lo);
        write_reg(plc_pkg::CFG_NODE_HI, hi);
        write_reg(plc_pkg::CFG_COUNT, plc_pkg::CFG_W'(cnt));
        write_reg(plc_pkg::CFG_MAX, plc_pkg::CFG_W'(mx));
        write_reg(plc_pkg::CFG_GAIN, plc_pkg::CFG_W'(g));
        cfg_valid <= 1'b0;
        cur_max = mx;
    endtask

    initial begin
        int                        cnt, mx, g;
        logic [plc_pkg::CFG_W-1:0] lo, hi;
        int                        swing_vals [NUM_SWING];
        swing_vals   = '{0, 1, 65, 66, 500, 998, 999, 1000, -1, 32767, -32768};
        in_valid     = 1'b0;
        sample_value = '0;
        cfg_valid    = 1'b0;
        cfg_index    = plc_pkg::CFG_NODE_LO;
        cfg_data     = '0;
        calm         = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: all nodes zero
        send_sample(-32768);
        send_sample(32767);

        // full-scale node swings with gain 2550; last segment runs past its width
        wait_drained();
        write_reg(CFG_SPARE, '1);
        apply_setting(NODES_SWING, 64'h7F80_007F_80FF_0180, 16, 1000, 2550);
        for (int i = 0; i < NUM_SWING; i++)
            send_sample(swing_vals[i]);

        // fewer than two nodes: pass-through
        wait_drained();
        apply_setting('1, '1, 0, 32767, 2550);
        send_sample(32767);
        send_sample(-32768);
        wait_drained();
        apply_setting('1, '1, 1, 1000, 10);
        send_sample(-5);

        // count above the node limit
        wait_drained();
        apply_setting(NODES_SWING, '0, 31, 32767, 10);
        send_sample(0);
        send_sample(32766);

        // zero span: pass-through
        wait_drained();
        apply_setting(NODES_SWING, NODES_SWING, 16, 0, 10);
        send_sample(12345);
        send_sample(-7);

        // span narrower than the node count: zero segment width
        wait_drained();
        apply_setting(NODES_SWING, NODES_SWING, 16, 5, 2550);
        send_sample(0);
        send_sample(4);
        send_sample(3);

        for (int p = 0; p < NUM_PHASES; p++) begin
            lo  = {$urandom, $urandom};
            hi  = {$urandom, $urandom};
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 16);
            mx  = $urandom_range(0, 1) ? $urandom_range(16, 300) : $urandom_range(16, 32767);
            g   = $urandom_range(0, 2550);
            case (p)
                0: begin cnt = 16; mx = 16; g = 2550; lo = NODES_SWING; end
                1: begin cnt = 16; mx = 32767; g = 2550; end
                2: begin cnt = 2; g = 0; end
                3: g = 10;
                default: ;
            endcase
            calm = (p == 4);
            wait_drained();
            apply_setting(lo, hi, cnt, mx, g);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 3 && k == PHASE_ITEMS / 2)
                    wait_drained();
                send_sample(pick_sample(cur_max));
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_piecewise_linear_curve OK");
        end else begin
            $display("tb_piecewise_linear_curve NOT OK");
        end
        $finish;
    end

endmodule
